@@ src/heq_pkg.sv @@
package heq_pkg;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;
  localparam logic [1:0] OP_MAP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FLAT      = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  localparam int PIXEL_W = 8;

  typedef struct packed {
    logic [1:0]         op;
    logic [PIXEL_W-1:0] pixel;
  } heq_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] equalized;
    logic [1:0]         status;
  } heq_out_t;

endpackage

@@ src/heq_ram.sv @@
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/histogram_equalization_core.sv @@
// Histogram equalisation engine for 8-bit grey levels. Each input item carries
// an operation: clear the histogram, count one pixel, build the mapping table,
// or map one pixel; every item yields exactly one result item. Items are handled
// one at a time. Clear, count and map each pass through accept, memory read (for
// count and map) and result. A build walks the levels twice over the single
// histogram read port: a scan for the lowest level present, then per level a
// read, an accumulate and a multiply, followed for levels at or above the lowest
// level present, unless the histogram is flat, by a restoring divide, and one
// table write. A finished result waits in an output register, and the next item
// is accepted while it waits. Histogram clearing is done at once by per-level
// valid flags, so no clearing pass follows reset.
module histogram_equalization_core #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  heq_pkg::heq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output heq_pkg::heq_out_t out_data
);

  import heq_pkg::*;

  localparam int LVL_W = $clog2(LEVELS);
  localparam int CB    = COUNT_BITS;
  localparam int NUM_W = CB + 8;
  localparam int REM_W = CB + 10;
  localparam int Q_W   = 9;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_RESP = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_MIN  = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV0 = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;

  localparam logic [CB-1:0]    CNT_MAX  = {CB{1'b1}};
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [LVL_W-1:0]   k_r, k_nxt;
  logic [CB-1:0]      total_r, total_nxt;
  logic [CB-1:0]      sum_r, sum_nxt;
  logic [CB-1:0]      minc_r, minc_nxt;
  logic [CB-1:0]      den_r, den_nxt;
  logic               flat_r, flat_nxt;
  logic               ready_r, ready_nxt;
  logic               sat_r, sat_nxt;
  logic [LEVELS-1:0]  valid_r, valid_nxt;
  logic               hv_q_r, hv_q_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [PIXEL_W-1:0] pend_eq_r, pend_eq_nxt;
  logic [1:0]         pend_st_r, pend_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  heq_out_t           out_data_r, out_data_nxt;

  logic [LVL_W-1:0]   lvl_idx;
  logic               accept;
  logic               k_last;
  logic               out_free;
  logic [REM_W-1:0]   trial;

  logic               h_we, h_re;
  logic [LVL_W-1:0]   h_raddr;
  logic [CB-1:0]      h_wdata, h_rdata;
  logic               t_we, t_re;
  logic [7:0]         t_wdata, t_rdata;

  // pixels beyond the level range fall into the top level
  assign lvl_idx = ({1'b0, in_data.pixel} >= 9'(LEVELS)) ? LVL_LAST
                                                          : in_data.pixel[LVL_W-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign k_last   = (k_r == LVL_LAST);
  assign out_free = !out_valid_r || out_ready;
  assign trial    = REM_W'({den_r, 1'b0}) << bit_r;

  // histogram memory access
  assign h_re    = (accept && in_data.op == OP_COUNT) ||
                   (state_r == S_SCAN && valid_r[k_r]) || (state_r == S_RD);
  assign h_raddr = (state_r == S_IDLE) ? lvl_idx : k_r;
  assign h_we    = (state_r == S_EXEC) && (op_r == OP_COUNT) && (total_r != CNT_MAX);
  assign h_wdata = (hv_q_r ? h_rdata : '0) + CB'(1);

  // mapping table access
  assign t_re    = accept && (in_data.op == OP_MAP);
  assign t_we    = (state_r == S_WR);
  assign t_wdata = (q_r > Q_W'(255)) ? 8'hFF : q_r[7:0];

  heq_ram #(.WIDTH(CB), .DEPTH(LEVELS)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (lvl_r),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  heq_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (k_r),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (lvl_idx),
    .rdata (t_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    minc_nxt      = minc_r;
    den_nxt       = den_r;
    flat_nxt      = flat_r;
    ready_nxt     = ready_r;
    sat_nxt       = sat_r;
    valid_nxt     = valid_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    pend_eq_nxt   = pend_eq_r;
    pend_st_nxt   = pend_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hv_q_nxt      = h_re ? valid_r[h_raddr] : hv_q_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          lvl_nxt   = lvl_idx;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_CLEAR: begin
            valid_nxt   = '0;
            total_nxt   = '0;
            sum_nxt     = '0;
            minc_nxt    = '0;
            ready_nxt   = 1'b0;
            sat_nxt     = 1'b0;
            pend_eq_nxt = '0;
            pend_st_nxt = ST_OK;
            state_nxt   = S_RESP;
          end
          OP_COUNT: begin
            // the total bounds every level count, so it alone decides saturation
            if (total_r == CNT_MAX) begin
              sat_nxt = 1'b1;
            end else begin
              valid_nxt[lvl_r] = 1'b1;
              total_nxt        = total_r + CB'(1);
            end
            ready_nxt   = 1'b0;
            pend_eq_nxt = '0;
            pend_st_nxt = (sat_r || total_r == CNT_MAX) ? ST_SAT : ST_OK;
            state_nxt   = S_RESP;
          end
          OP_BUILD: begin
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end
          OP_MAP: begin
            pend_eq_nxt = ready_r ? t_rdata : '0;
            pend_st_nxt = ready_r ? ST_OK : ST_NOT_BUILT;
            state_nxt   = S_RESP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // find the lowest level present; its count is the minimum
      S_SCAN: begin
        if (valid_r[k_r]) begin
          state_nxt = S_MIN;
        end else if (k_last) begin
          minc_nxt  = '0;
          state_nxt = S_PREP;
        end else begin
          k_nxt = k_r + LVL_W'(1);
        end
      end
      S_MIN: begin
        minc_nxt  = h_rdata;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        flat_nxt  = (total_r <= minc_r);
        den_nxt   = total_r - minc_r;
        sum_nxt   = '0;
        k_nxt     = '0;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_ACC;
      // cumulative count
      S_ACC: begin
        sum_nxt   = sum_r + (hv_q_r ? h_rdata : '0);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (flat_r || sum_r < minc_r) begin
          q_nxt     = '0;
          state_nxt = S_WR;
        end else begin
          num_nxt   = NUM_W'(sum_r - minc_r) * NUM_W'(LEVELS - 1);
          state_nxt = S_DIV0;
        end
      end
      // round half up: (2*num + den) / (2*den), quotient fits in nine bits
      S_DIV0: begin
        rem_nxt   = REM_W'({num_r, 1'b0}) + REM_W'(den_r);
        q_nxt     = '0;
        bit_nxt   = 4'd8;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
        if (bit_r == 4'd0) begin
          state_nxt = S_WR;
        end else begin
          bit_nxt = bit_r - 4'd1;
        end
      end
      S_WR: begin
        if (k_last) begin
          ready_nxt   = 1'b1;
          pend_eq_nxt = '0;
          pend_st_nxt = flat_r ? ST_FLAT : (sat_r ? ST_SAT : ST_OK);
          state_nxt   = S_RESP;
        end else begin
          k_nxt     = k_r + LVL_W'(1);
          state_nxt = S_RD;
        end
      end
      // hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.equalized = pend_eq_r;
          out_data_nxt.status    = pend_st_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      sum_r       <= '0;
      minc_r      <= '0;
      ready_r     <= 1'b0;
      sat_r       <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      minc_r      <= minc_nxt;
      ready_r     <= ready_nxt;
      sat_r       <= sat_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    lvl_r      <= lvl_nxt;
    k_r        <= k_nxt;
    den_r      <= den_nxt;
    flat_r     <= flat_nxt;
    hv_q_r     <= hv_q_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    pend_eq_r  <= pend_eq_nxt;
    pend_st_r  <= pend_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
